// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the countdown timer.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== rtl/core/cdt_pkg.sv =====
// Package for the countdown timer: command codes, constants and shared structs.
// No dependencies.
package cdt_pkg;
	localparam int ALARM_LIMIT = 10;
	localparam int TW = 23;
	localparam int AW = 4;
	localparam int DIV_STEPS = TW + AW + 1;

	localparam logic [2:0] CMD_TICK = 3'd0;
	localparam logic [2:0] CMD_SET = 3'd1;
	localparam logic [2:0] CMD_CANCEL = 3'd2;
	localparam logic [2:0] CMD_RESTART = 3'd3;
	localparam logic [2:0] CMD_VAC = 3'd4;
	localparam logic [2:0] CMD_VAC_CANCEL = 3'd5;
	localparam logic [2:0] CMD_ALARMS = 3'd6;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_NO_PRIOR = 2'd2;

	localparam logic [16:0] SECS_DAY = 17'd86400;
	localparam logic [16:0] SECS_HOUR = 17'd3600;
	localparam logic [16:0] SECS_MIN = 17'd60;
	localparam logic [5:0] MAX_UNITS = 6'd60;

	// Controller to datapath commands.
	typedef struct packed {
		logic exec;       // apply the item to the state
		logic div_start;  // begin threshold division
		logic div_step;   // one restoring division step
		logic div_done;   // write the quotient to the threshold
	} cdt_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic need_div;
		logic div_last;
	} cdt_stat_t;
endpackage

// ===== rtl/core/cdt_ctrl.sv =====
// Controller state machine for the countdown timer.
// Depends on cdt_pkg.
module cdt_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	output cdt_pkg::cdt_cmd_t cmd,
	input  cdt_pkg::cdt_stat_t stat
);
	import cdt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_DIV  = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t state_q;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.exec = in_valid;
			S_EXEC: cmd.div_start = stat.need_div;
			S_DIV: begin
				cmd.div_step = 1'b1;
				cmd.div_done = stat.div_last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_EXEC;
				S_EXEC: state_q <= stat.need_div ? S_DIV : S_OUT;
				S_DIV: if (stat.div_last) state_q <= S_OUT;
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/core/cdt_dp.sv =====
// Datapath of the countdown timer: state registers, item logic and a
// restoring divider for the alarm threshold. Depends on cdt_pkg.
module cdt_dp (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [7:0] cfg_data,
	input  logic [2:0] cmd_in,
	input  logic [1:0] unit,
	input  logic [5:0] amount,
	input  cdt_pkg::cdt_cmd_t cmd,
	output cdt_pkg::cdt_stat_t stat,
	output logic [1:0] status,
	output logic alarm_fired,
	output logic [3:0] alarm_slot,
	output logic expired,
	output logic checkpoint,
	output logic sync_due,
	output logic running,
	output logic [22:0] remaining,
	output logic vacation_active,
	output logic [22:0] vac_seconds
);
	import cdt_pkg::*;

	logic [7:0] ckpt_int_q, sync_int_q, save_q, sync_q;
	logic main_en_q, vac_en_q, recalc_q;
	logic [TW-1:0] main_rem_q, total_q, vac_rem_q, thr_q;
	logic [AW-1:0] acount_q, adone_q;
	logic [1:0] st_q;
	logic fired_q, exp_q, ckpt_q, syncf_q;
	logic [AW-1:0] aidx_q;

	// next-state values
	logic main_en_d, vac_en_d, recalc_d;
	logic [TW-1:0] main_rem_d, total_d, vac_rem_d;
	logic [AW-1:0] acount_d, adone_d;
	logic [7:0] save_d, sync_d, save_inc, sync_inc;
	logic [1:0] st_d;
	logic fired_d, exp_d, ckpt_d, syncf_d;
	logic [AW-1:0] aidx_d;
	logic [16:0] mult;
	logic [TW-1:0] vm1, mm1;

	// divider
	logic [DIV_STEPS-1:0] num_q, quo_q;
	logic [DIV_STEPS-1:0] rem_q;
	logic [AW:0] den_q;
	logic [4:0] cnt_q;
	logic [DIV_STEPS-1:0] rem_sh;
	logic [DIV_STEPS:0] rem_try;

	assign save_inc = save_q + 8'd1;
	assign sync_inc = sync_q + 8'd1;
	assign vm1 = vac_rem_q - 1'b1;
	assign mm1 = main_rem_q - 1'b1;

	always_comb begin
		case (unit)
			2'd0: mult = SECS_DAY;
			2'd1: mult = SECS_HOUR;
			2'd2: mult = SECS_MIN;
			default: mult = '0;
		endcase
	end

	always_comb begin
		main_en_d = main_en_q; vac_en_d = vac_en_q; main_rem_d = main_rem_q;
		total_d = total_q; vac_rem_d = vac_rem_q; acount_d = acount_q;
		adone_d = adone_q; save_d = save_q; sync_d = sync_q; recalc_d = 1'b0;
		st_d = ST_OK; fired_d = 1'b0; exp_d = 1'b0; ckpt_d = 1'b0;
		syncf_d = 1'b0; aidx_d = '0;
		case (cmd_in)
			CMD_TICK: begin
				if (vac_en_q && vac_rem_q != '0) begin
					vac_rem_d = vm1;
					if (vm1 == '0) begin
						vac_en_d = 1'b0;
						if (total_q != '0) begin
							main_rem_d = total_q;
							main_en_d = 1'b1;
							adone_d = '0;
							recalc_d = 1'b1;
						end
						ckpt_d = 1'b1;
						syncf_d = 1'b1;
					end else begin
						ckpt_d = (save_inc >= ckpt_int_q);
						save_d = ckpt_d ? 8'd0 : save_inc;
						syncf_d = (sync_inc >= sync_int_q);
						sync_d = syncf_d ? 8'd0 : sync_inc;
					end
				end else if (main_en_q && main_rem_q != '0) begin
					main_rem_d = mm1;
					if (thr_q != '0 && mm1 != '0 && mm1 <= thr_q) begin
						fired_d = 1'b1;
						aidx_d = adone_q;
						adone_d = adone_q + 1'b1;
						recalc_d = 1'b1;
					end
					if (mm1 == '0) begin
						main_en_d = 1'b0;
						ckpt_d = 1'b1;
						exp_d = 1'b1;
					end else begin
						ckpt_d = (save_inc >= ckpt_int_q);
						save_d = ckpt_d ? 8'd0 : save_inc;
						syncf_d = (sync_inc >= sync_int_q);
						sync_d = syncf_d ? 8'd0 : sync_inc;
					end
				end
			end
			CMD_SET: begin
				if (amount == '0 || amount > MAX_UNITS || mult == '0) begin
					st_d = ST_INVALID;
				end else begin
					total_d = TW'(amount * mult);
					main_rem_d = total_d;
					main_en_d = 1'b1;
					save_d = '0;
					adone_d = '0;
					if ({2'b0, acount_q} > amount[5:1]) acount_d = AW'(amount[5:1]);
					recalc_d = 1'b1;
					ckpt_d = 1'b1;
				end
			end
			CMD_CANCEL: begin
				main_en_d = 1'b0;
				main_rem_d = '0;
				save_d = '0;
				ckpt_d = 1'b1;
			end
			CMD_RESTART: begin
				if (total_q == '0) begin
					st_d = ST_NO_PRIOR;
				end else begin
					main_rem_d = total_q;
					main_en_d = 1'b1;
					save_d = '0;
					adone_d = '0;
					recalc_d = 1'b1;
					ckpt_d = 1'b1;
				end
			end
			CMD_VAC: begin
				if (amount == '0 || amount > MAX_UNITS) begin
					st_d = ST_INVALID;
				end else begin
					if (total_q != '0) main_rem_d = total_q;
					main_en_d = 1'b0;
					vac_rem_d = TW'(amount * SECS_DAY);
					vac_en_d = 1'b1;
					save_d = '0;
					ckpt_d = 1'b1;
				end
			end
			CMD_VAC_CANCEL: begin
				vac_en_d = 1'b0;
				vac_rem_d = '0;
				save_d = '0;
				if (total_q != '0) begin
					main_rem_d = total_q;
					main_en_d = 1'b1;
				end
				ckpt_d = 1'b1;
			end
			CMD_ALARMS: begin
				if (amount > 6'(ALARM_LIMIT)) begin
					st_d = ST_INVALID;
				end else begin
					acount_d = AW'(amount);
					ckpt_d = 1'b1;
				end
			end
			default: st_d = ST_INVALID;
		endcase
	end

	// Threshold is zero unless alarms remain; otherwise a division is run.
	assign stat.need_div = recalc_q && acount_q != '0 && total_q != '0 && adone_q < acount_q;
	assign stat.div_last = (cnt_q == 5'(DIV_STEPS - 1));

	assign rem_sh = {rem_q[DIV_STEPS-2:0], num_q[DIV_STEPS-1]};
	assign rem_try = {1'b0, rem_sh} - {{(DIV_STEPS-AW){1'b0}}, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ckpt_int_q <= 8'd60; sync_int_q <= 8'd2;
			main_en_q <= 1'b0; vac_en_q <= 1'b0; recalc_q <= 1'b0;
			main_rem_q <= '0; total_q <= '0; vac_rem_q <= '0; thr_q <= '0;
			acount_q <= AW'(3); adone_q <= '0; save_q <= '0; sync_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index) sync_int_q <= cfg_data;
				else ckpt_int_q <= cfg_data;
			end
			if (cmd.exec) begin
				main_en_q <= main_en_d; vac_en_q <= vac_en_d; main_rem_q <= main_rem_d;
				total_q <= total_d; vac_rem_q <= vac_rem_d; acount_q <= acount_d;
				adone_q <= adone_d; save_q <= save_d; sync_q <= sync_d;
				recalc_q <= recalc_d;
			end
			if (recalc_q && !cmd.exec && !stat.need_div && !cmd.div_step) begin
				thr_q <= '0;
				recalc_q <= 1'b0;
			end
			if (cmd.div_start) cnt_q <= '0;
			else if (cmd.div_step) cnt_q <= cnt_q + 5'd1;
			if (cmd.div_done) begin
				thr_q <= TW'(rem_try[DIV_STEPS] ? {quo_q[DIV_STEPS-2:0], 1'b0}
					: {quo_q[DIV_STEPS-2:0], 1'b1});
				recalc_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			st_q <= st_d; fired_q <= fired_d; exp_q <= exp_d; ckpt_q <= ckpt_d;
			syncf_q <= syncf_d; aidx_q <= aidx_d;
		end
		if (cmd.div_start) begin
			// total * (count - done) fits 27 bits, one narrow multiply
			num_q <= DIV_STEPS'(total_q * (acount_q - adone_q));
			den_q <= {1'b0, acount_q} + 1'b1;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			num_q <= {num_q[DIV_STEPS-2:0], 1'b0};
			rem_q <= rem_try[DIV_STEPS] ? rem_sh : rem_try[DIV_STEPS-1:0];
			quo_q <= {quo_q[DIV_STEPS-2:0], ~rem_try[DIV_STEPS]};
		end
	end

	assign status = st_q;
	assign alarm_fired = fired_q;
	assign alarm_slot = aidx_q;
	assign expired = exp_q;
	assign checkpoint = ckpt_q;
	assign sync_due = syncf_q;
	assign running = main_en_q;
	assign remaining = main_rem_q;
	assign vacation_active = vac_en_q;
	assign vac_seconds = vac_rem_q;
endmodule

// ===== rtl/core/countdown_timer_with_vacation_alarms_top.sv =====
// Countdown timer with vacation hold: a taken request passes through S_EXEC
// (and S_DIV, when the alarm threshold is recomputed by the 28-step restoring
// divider) to S_OUT, where its result is offered; one request is in flight at
// a time, so no new request is taken until that result has been accepted.
// Reset (arst_n, asynchronous) clears the timer state but not the result registers, sets the alarm count
// to 3 and the checkpoint and sync intervals to 60 and 2.
// Top level. Depends on cdt_pkg, cdt_ctrl, cdt_dp and assert_macros.svh.
`include "assert_macros.svh"
module countdown_timer_with_vacation_alarms_top (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [7:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [2:0] cmd,
	input  logic [1:0] unit,
	input  logic [5:0] amount,
	output logic out_valid,
	input  logic out_stall,
	output logic [1:0] status,
	output logic alarm_fired,
	output logic [3:0] alarm_slot,
	output logic expired,
	output logic checkpoint,
	output logic sync_due,
	output logic running,
	output logic [22:0] remaining,
	output logic vacation_active,
	output logic [22:0] vac_seconds
);
	import cdt_pkg::*;

	cdt_cmd_t ctl;
	cdt_stat_t st;

	cdt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .cmd(ctl), .stat(st)
	);

	cdt_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .cmd_in(cmd), .unit(unit), .amount(amount),
		.cmd(ctl), .stat(st), .status(status), .alarm_fired(alarm_fired),
		.alarm_slot(alarm_slot), .expired(expired), .checkpoint(checkpoint),
		.sync_due(sync_due), .running(running), .remaining(remaining),
		.vacation_active(vacation_active), .vac_seconds(vac_seconds)
	);

	`ASSERT_IMP(a_no_accept_while_out, clk, arst_n, out_valid, in_stall)
	`ASSERT_IMP(a_expired_stops, clk, arst_n, out_valid && expired, !running)
	`ASSERT_IMP(a_fail_no_ckpt, clk, arst_n, out_valid && status != ST_OK, !checkpoint)
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, in_valid && !in_stall, in_stall)
endmodule
